/* design/sli_pkg.sv */
// Package for the sorted list block: sizes, opcodes, status codes and the
// command that the control logic broadcasts to the chain of cells.
// No dependencies.
package sli_pkg;

    localparam int CAPACITY = 32;
    localparam int VAL_W    = 31;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);

    typedef enum logic [1:0] {
        OPC_INSERT = 2'd0,
        OPC_DELETE = 2'd1,
        OPC_READ   = 2'd2,
        OPC_CLEAR  = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        STS_DONE     = 3'd0,
        STS_FULL     = 3'd1,
        STS_NOTFOUND = 3'd2,
        STS_ELEM     = 3'd3,
        STS_EMPTY    = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE,
        CELL_ROTATE
    } t_cell_op;

    typedef struct packed {
        t_cell_op           op;
        logic [VAL_W-1:0]   value;
        logic [CNT_W-1:0]   count;
    } t_cell_cmd;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } t_state;

endpackage

/* design/sorted_list_insert_delete.sv */
// Sorted list store: keeps up to CAPACITY 31-bit values in ascending order in a
// chain of cells. Insert and delete are decided in every cell at once, and clear
// resets the count; each gets one transfer on the result stream. A readout
// enters its read state, then rotates the chain one cell per cycle while the
// result register is free or being emptied, giving one transfer per cycle for
// each stored value (tlast on the final one), or a single empty result when
// nothing is stored. New commands are taken only in idle and on that condition.
// Depends on sli_pkg and sli_chain.
module sorted_list_insert_delete
    import sli_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [30:0] value, [31] zero
    input  logic [1:0]  i_s_tuser,   // [1:0] opcode
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [30:0] item_value, [31] zero
    output logic [2:0]  o_m_tuser,   // [2:0] status
    output logic        o_m_tlast
);

    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [IDX_W-1:0] r_rd;
    logic [IDX_W-1:0] n_rd;
    logic             r_ovalid;
    logic             n_ovalid;
    t_status          r_status;
    t_status          n_status;
    logic [VAL_W-1:0] r_oval;
    logic [VAL_W-1:0] n_oval;
    logic             r_olast;
    logic             n_olast;

    t_cell_cmd        w_cmd;
    logic [VAL_W-1:0] w_head;
    logic             w_found;
    logic             w_free;
    logic             w_acc;
    logic             w_full;
    logic             w_rd_last;
    t_opcode          w_opc;

    assign w_free    = !r_ovalid || i_m_tready;
    assign o_s_tready = (r_state == ST_IDLE) && w_free;
    assign w_acc     = i_s_tvalid && o_s_tready;
    assign w_opc     = t_opcode'(i_s_tuser);
    assign w_full    = r_count >= CNT_W'(CAPACITY);
    assign w_rd_last = ({1'b0, r_rd} + CNT_W'(1)) == r_count;

    sli_chain u_chain (
        .i_clk      (i_clk),
        .i_cmd      (w_cmd),
        .o_head_val (w_head),
        .o_found    (w_found)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_acc && w_opc == OPC_READ && r_count != '0) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                if (w_free && w_rd_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Cell commands, count, read index and result register.
    always_comb begin
        w_cmd.op    = CELL_HOLD;
        w_cmd.value = i_s_tdata[VAL_W-1:0];
        w_cmd.count = r_count;
        n_count     = r_count;
        n_rd        = r_rd;
        n_ovalid    = r_ovalid && !i_m_tready;
        n_status    = r_status;
        n_oval      = r_oval;
        n_olast     = r_olast;
        case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    n_oval  = '0;
                    n_olast = 1'b1;
                    case (w_opc)
                        OPC_INSERT: begin
                            n_ovalid = 1'b1;
                            if (w_full) begin
                                n_status = STS_FULL;
                            end else begin
                                w_cmd.op = CELL_INSERT;
                                n_count  = r_count + CNT_W'(1);
                                n_status = STS_DONE;
                            end
                        end
                        OPC_DELETE: begin
                            n_ovalid = 1'b1;
                            w_cmd.op = CELL_DELETE;
                            if (w_found) begin
                                n_count  = r_count - CNT_W'(1);
                                n_status = STS_DONE;
                            end else begin
                                n_status = STS_NOTFOUND;
                            end
                        end
                        OPC_READ: begin
                            n_rd = '0;
                            if (r_count == '0) begin
                                n_ovalid = 1'b1;
                                n_status = STS_EMPTY;
                            end
                        end
                        default: begin
                            n_ovalid = 1'b1;
                            n_count  = '0;
                            n_status = STS_DONE;
                        end
                    endcase
                end
            end
            ST_READ: begin
                if (w_free) begin
                    // The head value goes out while the ring moves one place.
                    w_cmd.op = CELL_ROTATE;
                    n_ovalid = 1'b1;
                    n_status = STS_ELEM;
                    n_oval   = w_head;
                    n_olast  = w_rd_last;
                    n_rd     = r_rd + IDX_W'(1);
                end
            end
            default: begin
                w_cmd.op = CELL_HOLD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_rd     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_rd     <= n_rd;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_oval   <= n_oval;
        r_olast  <= n_olast;
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {1'b0, r_oval};
    assign o_m_tuser  = r_status;
    assign o_m_tlast  = r_olast;

endmodule

/* design/sli_cell.sv */
// One storage cell of the sorted chain: holds one value and moves it to or
// from its neighbors on insert, delete and readout rotation.
// Depends on sli_pkg.
module sli_cell
    import sli_pkg::*;
(
    input  logic             i_clk,
    input  t_cell_cmd        i_cmd,
    input  logic [IDX_W-1:0] i_idx,
    input  logic             i_found,
    input  logic [VAL_W-1:0] i_left_val,
    input  logic             i_left_p,
    input  logic [VAL_W-1:0] i_right_val,
    input  logic [VAL_W-1:0] i_head_val,
    output logic [VAL_W-1:0] o_val,
    output logic             o_p,
    output logic             o_eq
);

    logic [VAL_W-1:0] r_val;
    logic [VAL_W-1:0] n_val;
    logic             w_valid;
    logic             w_q;
    logic             w_wrap;

    assign w_valid = {1'b0, i_idx} < i_cmd.count;
    // o_p marks the cells at or after the insert position; the list is sorted,
    // so the flags rise once along the chain and never fall again.
    assign o_p     = !w_valid || (r_val > i_cmd.value);
    assign w_q     = w_valid && (r_val >= i_cmd.value);
    assign o_eq    = w_valid && (r_val == i_cmd.value);
    // The last valid cell closes the ring during readout.
    assign w_wrap  = ({1'b0, i_idx} + CNT_W'(1)) == i_cmd.count;
    assign o_val   = r_val;

    always_comb begin
        n_val = r_val;
        case (i_cmd.op)
            CELL_INSERT: begin
                if (i_left_p) begin
                    n_val = i_left_val;
                end else if (o_p) begin
                    n_val = i_cmd.value;
                end
            end
            CELL_DELETE: begin
                if (i_found && w_q) begin
                    n_val = i_right_val;
                end
            end
            CELL_ROTATE: begin
                n_val = w_wrap ? i_head_val : i_right_val;
            end
            default: begin
                n_val = r_val;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

/* design/sli_chain.sv */
// Row of CAPACITY storage cells with neighbor links, plus the match flag
// that a delete needs from the whole row.
// Depends on sli_pkg and sli_cell.
module sli_chain
    import sli_pkg::*;
(
    input  logic             i_clk,
    input  t_cell_cmd        i_cmd,
    output logic [VAL_W-1:0] o_head_val,
    output logic             o_found
);

    logic [VAL_W-1:0] w_val   [CAPACITY];
    logic [VAL_W-1:0] w_left  [CAPACITY];
    logic [VAL_W-1:0] w_right [CAPACITY];
    logic             w_p     [CAPACITY];
    logic             w_lp    [CAPACITY];
    logic [CAPACITY-1:0] w_eq;

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            w_left[i]  = (i == 0) ? i_cmd.value : w_val[(i + CAPACITY - 1) % CAPACITY];
            w_lp[i]    = (i == 0) ? 1'b0 : w_p[(i + CAPACITY - 1) % CAPACITY];
            w_right[i] = w_val[(i + 1) % CAPACITY];
        end
    end

    assign o_head_val = w_val[0];
    assign o_found    = |w_eq;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        sli_cell u_cell (
            .i_clk       (i_clk),
            .i_cmd       (i_cmd),
            .i_idx       (IDX_W'(g)),
            .i_found     (o_found),
            .i_left_val  (w_left[g]),
            .i_left_p    (w_lp[g]),
            .i_right_val (w_right[g]),
            .i_head_val  (w_val[0]),
            .o_val       (w_val[g]),
            .o_p         (w_p[g]),
            .o_eq        (w_eq[g])
        );
    end

endmodule

/* dv/tb_sorted_list_insert_delete.sv */
`timescale 1ns / 100ps
// Testbench for sorted_list_insert_delete: streams insert, delete, readout and clear
// commands with random gaps and back-pressure and checks every result transfer.
// Depends on sli_pkg and the RTL of the sorted list store.
module tb_sorted_list_insert_delete
    import sli_pkg::*;
();

    localparam int RESET_CYCLES     = 2;
    localparam int DRAIN_CYCLES     = 2 * CAPACITY + 20;
    localparam int LONG_HOLD_CYCLES = 150;
    localparam int LONG_HOLD_AT     = 60;
    localparam int MAX_REPORTS      = 10;
    localparam int RANDOM_CMDS      = 180;
    localparam longint TIMEOUT_NS   = 2_000_000;
    localparam logic [VAL_W-1:0] VAL_MAX = '1;

    typedef struct {
        t_opcode          op;
        logic [VAL_W-1:0] value;
        bit               drain_first;
    } t_cmd;

    typedef struct {
        t_status          status;
        logic [VAL_W-1:0] value;
        logic             last;
    } t_result;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    t_cmd             cmd_queue[$];
    t_result          expected_results[$];
    logic [VAL_W-1:0] sorted_copy[$];
    logic [VAL_W-1:0] pool[8];

    bit s_taken    = 1'b0;
    bit m_taken    = 1'b0;
    bit send_calm  = 1'b0;
    bit recv_calm  = 1'b0;
    bit hold_done  = 1'b0;
    int send_gap   = 0;
    int recv_wait  = 0;
    int hold_left  = 0;
    int cmds_accepted  = 0;
    int results_seen   = 0;
    int mismatch_count = 0;
    int deepest_list   = 0;
    int status_hits[5] = '{default: 0};

    sorted_list_insert_delete DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Calm stretches with no idling alternate with stretches of randomly drawn idle gaps.
    function automatic int draw_gap(inout bit calm);
        if ($urandom_range(0, 15) == 0) calm = !calm;
        return calm ? 0 : $urandom_range(0, 8);
    endfunction

    function void add_cmd(t_opcode op, logic [VAL_W-1:0] value, bit drain_first);
        cmd_queue.push_back('{op, value, drain_first});
    endfunction

    function logic [VAL_W-1:0] pick_value();
        return ($urandom_range(0, 4) == 0) ? VAL_W'($urandom) : pool[$urandom_range(0, 7)];
    endfunction

    function void queue_result(t_status status, logic [VAL_W-1:0] value, logic last);
        expected_results.push_back('{status, value, last});
    endfunction

    function void report_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) $display("%0t ns: %s", $time, what);
    endfunction

    // Applies one accepted command to the shadow list and queues the results it causes.
    function void apply_to_list(t_opcode op, logic [VAL_W-1:0] v);
        int pos;
        pos = 0;
        case (op)
            OPC_INSERT: begin
                if (sorted_copy.size() >= CAPACITY) begin
                    queue_result(STS_FULL, '0, 1'b1);
                end else begin
                    // Equal values keep arrival order: go past every entry not greater.
                    while (pos < sorted_copy.size() && sorted_copy[pos] <= v) pos++;
                    sorted_copy.insert(pos, v);
                    queue_result(STS_DONE, '0, 1'b1);
                end
            end
            OPC_DELETE: begin
                while (pos < sorted_copy.size() && sorted_copy[pos] != v) pos++;
                if (pos >= sorted_copy.size()) begin
                    queue_result(STS_NOTFOUND, '0, 1'b1);
                end else begin
                    sorted_copy.delete(pos);
                    queue_result(STS_DONE, '0, 1'b1);
                end
            end
            OPC_READ: begin
                if (sorted_copy.size() == 0) begin
                    queue_result(STS_EMPTY, '0, 1'b1);
                end else begin
                    foreach (sorted_copy[i])
                        queue_result(STS_ELEM, sorted_copy[i], i == sorted_copy.size() - 1);
                end
            end
            default: begin
                sorted_copy.delete();
                queue_result(STS_DONE, '0, 1'b1);
            end
        endcase
        if (sorted_copy.size() > deepest_list) deepest_list = sorted_copy.size();
    endfunction

    // Sampling of both streams, prediction and checking.
    always @(posedge i_clk) begin
        t_result want;
        s_taken <= i_rst_n && s_tvalid && s_tready;
        m_taken <= i_rst_n && m_tvalid && m_tready;
        if (i_rst_n) begin
            if (s_tvalid && s_tready) begin
                apply_to_list(t_opcode'(s_tuser), s_tdata[VAL_W-1:0]);
                cmds_accepted++;
            end
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (m_tuser < 5) status_hits[m_tuser]++;
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf(
                        "result with nothing expected: status %0d value %0h last %0b",
                        m_tuser, m_tdata, m_tlast));
                end else begin
                    want = expected_results.pop_front();
                    if (m_tuser !== want.status || m_tdata !== {1'b0, want.value}
                            || m_tlast !== want.last) begin
                        report_mismatch($sformatf(
                            {"result %0d: expected status %0d value %0h last %0b, ",
                             "got status %0d value %0h last %0b"},
                            results_seen, want.status, {1'b0, want.value}, want.last,
                            m_tuser, m_tdata, m_tlast));
                    end
                end
            end
        end
    end

    // Command driver: a held transfer stays up until taken, then an idle gap.
    always @(negedge i_clk) begin
        t_cmd next_cmd;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !s_taken) begin
            s_tvalid <= 1'b1;
        end else if (send_gap > 0) begin
            s_tvalid <= 1'b0;
            send_gap <= send_gap - 1;
        end else if (cmd_queue.size() > 0
                && !(cmd_queue[0].drain_first && expected_results.size() > 0)) begin
            next_cmd = cmd_queue.pop_front();
            s_tdata  <= {1'b0, next_cmd.value};
            s_tuser  <= next_cmd.op;
            s_tvalid <= 1'b1;
            send_gap <= draw_gap(send_calm);
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // Result receiver: random stall after each transfer, plus one long hold-off
    // while commands keep coming so the block backs up into its input.
    always @(negedge i_clk) begin
        int w;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && cmds_accepted >= LONG_HOLD_AT) begin
            hold_done <= 1'b1;
            hold_left <= LONG_HOLD_CYCLES - 1;
            m_tready  <= 1'b0;
        end else if (m_taken) begin
            w = draw_gap(recv_calm);
            m_tready  <= (w == 0);
            recv_wait <= (w > 0) ? w - 1 : 0;
        end else if (recv_wait > 0) begin
            m_tready  <= 1'b0;
            recv_wait <= recv_wait - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    initial begin
        int random_cmds;
        int scenario;
        int r;
        int d;
        random_cmds = 0;

        // Directed part: empty store, extremes, duplicates, misses, clear.
        add_cmd(OPC_READ,   VAL_MAX, 1'b0);
        add_cmd(OPC_DELETE, '0, 1'b0);
        add_cmd(OPC_INSERT, VAL_MAX, 1'b0);
        add_cmd(OPC_INSERT, '0, 1'b0);
        add_cmd(OPC_INSERT, 31'd5, 1'b0);
        add_cmd(OPC_INSERT, 31'd5, 1'b0);
        add_cmd(OPC_INSERT, 31'd4, 1'b0);
        add_cmd(OPC_INSERT, VAL_MAX, 1'b0);
        add_cmd(OPC_READ,   31'h2AAA_AAAA, 1'b0);
        add_cmd(OPC_DELETE, 31'd5, 1'b0);
        add_cmd(OPC_DELETE, 31'd6, 1'b0);
        add_cmd(OPC_DELETE, VAL_MAX, 1'b0);
        add_cmd(OPC_DELETE, '0, 1'b0);
        add_cmd(OPC_READ,   '0, 1'b0);
        add_cmd(OPC_INSERT, 31'h2AAA_AAAA, 1'b0);
        add_cmd(OPC_INSERT, 31'h5555_5555, 1'b0);
        add_cmd(OPC_CLEAR,  VAL_MAX, 1'b1);
        add_cmd(OPC_READ,   31'h5555_5555, 1'b0);
        add_cmd(OPC_DELETE, 31'h2AAA_AAAA, 1'b0);
        add_cmd(OPC_INSERT, 31'd1, 1'b0);
        add_cmd(OPC_READ,   '0, 1'b0);
        add_cmd(OPC_CLEAR,  '0, 1'b0);

        // Random part: fill-to-full runs and mixed runs over a small value pool,
        // so duplicates and delete hits are common.
        while (random_cmds < RANDOM_CMDS) begin
            foreach (pool[i]) pool[i] = VAL_W'($urandom);
            if ($urandom_range(0, 3) == 0) pool[0] = '0;
            if ($urandom_range(0, 3) == 0) pool[1] = VAL_MAX;
            if ($urandom_range(0, 1) == 0) pool[2] = VAL_W'($urandom_range(0, 3));
            scenario = (random_cmds == 0) ? 0 : $urandom_range(0, 3);
            if (scenario == 0) begin
                add_cmd(OPC_CLEAR, VAL_W'($urandom), 1'b1);
                r = CAPACITY + $urandom_range(1, 4);
                repeat (r) add_cmd(OPC_INSERT, pick_value(), 1'b0);
                add_cmd(OPC_READ, VAL_W'($urandom), 1'b0);
                d = $urandom_range(1, 6);
                repeat (d) add_cmd(OPC_DELETE, pick_value(), 1'b0);
                add_cmd(OPC_READ, VAL_W'($urandom), 1'b0);
                random_cmds += r + d + 3;
            end else begin
                repeat ($urandom_range(10, 20)) begin
                    r = $urandom_range(0, 19);
                    if (r < 9)
                        add_cmd(OPC_INSERT, pick_value(), $urandom_range(0, 15) == 0);
                    else if (r < 15)
                        add_cmd(OPC_DELETE, pick_value(), 1'b0);
                    else if (r < 18)
                        add_cmd(OPC_READ, VAL_W'($urandom), 1'b0);
                    else
                        add_cmd(OPC_CLEAR, VAL_W'($urandom), 1'b0);
                    random_cmds++;
                end
            end
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_queue.size() > 0 || s_tvalid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d commands (%0d random), checked %0d results, deepest list %0d/%0d.",
                 cmds_accepted, random_cmds, results_seen, deepest_list, CAPACITY);
        $display("Status mix: done %0d, full %0d, not found %0d, element %0d, empty %0d.",
                 status_hits[0], status_hits[1], status_hits[2], status_hits[3],
                 status_hits[4]);
        if (mismatch_count == 0)
            $display("sorted_list_insert_delete regression: pass");
        else
            $display("sorted_list_insert_delete regression: fail");
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Timed out with %0d results still expected.", expected_results.size());
        $display("sorted_list_insert_delete regression: fail");
        $finish;
    end

endmodule
